// File: rtl/core/bbc_pkg.sv
`default_nettype none

package bbc_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int STATE_BITS   = 40;
    localparam int COEF_BITS    = 24;
    localparam int COEF_FRAC    = 22;
    localparam int THR_BITS     = 16;
    localparam int CFG_IDX_BITS = 4;
    localparam int CFG_DATA_BITS = COEF_BITS;

    localparam int PROD_BITS   = COEF_BITS + SAMPLE_BITS;
    // room for the doubled and negated b0*x product plus the rounding offset
    localparam int RND_IN_BITS = PROD_BITS + 2;
    localparam int RND_BITS    = RND_IN_BITS - COEF_FRAC;
    localparam int ACC_BITS    = ((RND_BITS > STATE_BITS) ? RND_BITS : STATE_BITS) + 2;

    typedef logic signed [SAMPLE_BITS-1:0]  t_sample;
    typedef logic signed [COEF_BITS-1:0]    t_coef;
    typedef logic signed [STATE_BITS-1:0]   t_state_w;
    typedef logic signed [PROD_BITS-1:0]    t_prod;
    typedef logic signed [RND_IN_BITS-1:0]  t_rnd_in;
    typedef logic signed [RND_BITS-1:0]     t_rnd;
    typedef logic signed [ACC_BITS-1:0]     t_acc;
    typedef logic [STATE_BITS-1:0]          t_mag;
    typedef logic [THR_BITS-1:0]            t_thr;
    typedef logic [CFG_IDX_BITS-1:0]        t_cfg_index;
    typedef logic [CFG_DATA_BITS-1:0]       t_cfg_data;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MODE = 4'd0,
        REG_FB0  = 4'd1,
        REG_FA1  = 4'd2,
        REG_FA2  = 4'd3,
        REG_SB0  = 4'd4,
        REG_SA1  = 4'd5,
        REG_SA2  = 4'd6,
        REG_THR  = 4'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MB,
        S_YC,
        S_M1,
        S_M2,
        S_N2,
        S_FL
    } t_seq_state;

    typedef enum logic [1:0] {
        MUL_B0,
        MUL_A1,
        MUL_A2
    } t_mul_sel;

    typedef struct packed {
        logic  mode;
        t_coef fb0;
        t_coef fa1;
        t_coef fa2;
        t_coef sb0;
        t_coef sa1;
        t_coef sa2;
        t_thr  thr;
    } t_cfg;

    typedef struct packed {
        logic     sec;
        logic     load_x;
        logic     pass_y;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     cap_y;
        logic     cap_n1;
        logic     cap_n2;
        logic     commit;
        logic     clr_second;
        logic     load_out;
    } t_dp_ctrl;

    localparam t_rnd_in RND_HALF  = t_rnd_in'(1) <<< (COEF_FRAC - 1);
    localparam t_acc    SMP_MAX   = (t_acc'(1) <<< (SAMPLE_BITS - 1)) - t_acc'(1);
    localparam t_acc    SMP_MIN   = -SMP_MAX - t_acc'(1);
    localparam t_acc    STATE_MAX = (t_acc'(1) <<< (STATE_BITS - 1)) - t_acc'(1);
    localparam t_acc    STATE_MIN = -STATE_MAX - t_acc'(1);

    // round half up to the state grid, floor shift
    function automatic t_rnd rnd(input t_rnd_in p);
        t_rnd_in t;
        t = p + RND_HALF;
        return t_rnd'(t[RND_IN_BITS-1:COEF_FRAC]);
    endfunction

    function automatic t_sample sat_sample(input t_acc v);
        t_acc r;
        if (v > SMP_MAX) begin
            r = SMP_MAX;
        end else if (v < SMP_MIN) begin
            r = SMP_MIN;
        end else begin
            r = v;
        end
        return t_sample'(r[SAMPLE_BITS-1:0]);
    endfunction

    function automatic t_state_w sat_state(input t_acc v);
        t_acc r;
        if (v > STATE_MAX) begin
            r = STATE_MAX;
        end else if (v < STATE_MIN) begin
            r = STATE_MIN;
        end else begin
            r = v;
        end
        return t_state_w'(r[STATE_BITS-1:0]);
    endfunction

    function automatic t_mag mag(input t_state_w v);
        t_state_w n;
        n = -v;
        return v[STATE_BITS-1] ? t_mag'(n) : t_mag'(v);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/bbc_ifs.sv
`default_nettype none

interface bbc_in_if;
    logic               valid;
    logic               ready;
    bbc_pkg::t_sample   sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface bbc_out_if;
    logic               valid;
    logic               ready;
    bbc_pkg::t_sample   sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface bbc_cfg_if;
    logic                   valid;
    logic                   ready;
    bbc_pkg::t_cfg_index    index;
    bbc_pkg::t_cfg_data     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bbc_cfg_regs.sv
`default_nettype none

module bbc_cfg_regs (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire bbc_pkg::t_cfg_index    i_index,
    input  wire bbc_pkg::t_cfg_data     i_data,
    output bbc_pkg::t_cfg               o_cfg
);

    bbc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_valid) begin
            case (i_index)
                bbc_pkg::REG_MODE: r_cfg.mode <= i_data[0];
                bbc_pkg::REG_FB0:  r_cfg.fb0  <= bbc_pkg::t_coef'(i_data);
                bbc_pkg::REG_FA1:  r_cfg.fa1  <= bbc_pkg::t_coef'(i_data);
                bbc_pkg::REG_FA2:  r_cfg.fa2  <= bbc_pkg::t_coef'(i_data);
                bbc_pkg::REG_SB0:  r_cfg.sb0  <= bbc_pkg::t_coef'(i_data);
                bbc_pkg::REG_SA1:  r_cfg.sa1  <= bbc_pkg::t_coef'(i_data);
                bbc_pkg::REG_SA2:  r_cfg.sa2  <= bbc_pkg::t_coef'(i_data);
                bbc_pkg::REG_THR:  r_cfg.thr  <= i_data[bbc_pkg::THR_BITS-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/core/bbc_datapath.sv
`default_nettype none

module bbc_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bbc_pkg::t_cfg      i_cfg,
    input  wire bbc_pkg::t_dp_ctrl  i_ctrl,
    input  wire bbc_pkg::t_sample   i_sample,
    output bbc_pkg::t_sample        o_sample
);

    bbc_pkg::t_sample   r_x;
    bbc_pkg::t_sample   r_y;
    bbc_pkg::t_sample   r_out;
    bbc_pkg::t_prod     r_prod;
    bbc_pkg::t_rnd      r_rb;
    bbc_pkg::t_rnd      r_rkb;
    bbc_pkg::t_state_w  r_n1;
    bbc_pkg::t_state_w  r_n2;
    bbc_pkg::t_state_w  r_s1 [2];
    bbc_pkg::t_state_w  r_s2 [2];

    bbc_pkg::t_coef     w_coef;
    bbc_pkg::t_sample   w_mul_b;
    bbc_pkg::t_prod     w_prod;
    bbc_pkg::t_rnd_in   w_pb_ext;
    bbc_pkg::t_rnd_in   w_pb2;
    bbc_pkg::t_rnd_in   w_pk;
    bbc_pkg::t_rnd      w_rb;
    bbc_pkg::t_rnd      w_rkb;
    bbc_pkg::t_rnd      w_rp;
    bbc_pkg::t_sample   w_y;
    bbc_pkg::t_state_w  w_n1;
    bbc_pkg::t_state_w  w_n2;
    bbc_pkg::t_state_w  w_s1_cur;
    bbc_pkg::t_state_w  w_s2_cur;
    bbc_pkg::t_mag      w_m1;
    bbc_pkg::t_mag      w_m2;
    bbc_pkg::t_mag      w_mmax;
    logic               w_flush;

    // shared multiplier operand selection
    always_comb begin
        case (i_ctrl.mul_sel)
            bbc_pkg::MUL_B0: w_coef = i_ctrl.sec ? i_cfg.sb0 : i_cfg.fb0;
            bbc_pkg::MUL_A1: w_coef = i_ctrl.sec ? i_cfg.sa1 : i_cfg.fa1;
            bbc_pkg::MUL_A2: w_coef = i_ctrl.sec ? i_cfg.sa2 : i_cfg.fa2;
            default:         w_coef = '0;
        endcase
    end

    assign w_mul_b = (i_ctrl.mul_sel == bbc_pkg::MUL_B0) ? r_x : r_y;
    assign w_prod  = bbc_pkg::t_prod'(w_coef) * bbc_pkg::t_prod'(w_mul_b);

    assign w_s1_cur = r_s1[i_ctrl.sec];
    assign w_s2_cur = r_s2[i_ctrl.sec];

    // b1*x is twice b0*x, negated for the highpass first section
    assign w_pb_ext = bbc_pkg::t_rnd_in'(r_prod);
    assign w_pb2    = w_pb_ext <<< 1;
    assign w_pk     = (i_cfg.mode && !i_ctrl.sec) ? -w_pb2 : w_pb2;
    assign w_rb     = bbc_pkg::rnd(w_pb_ext);
    assign w_rkb    = bbc_pkg::rnd(w_pk);
    assign w_rp     = bbc_pkg::rnd(w_pb_ext);

    assign w_y  = bbc_pkg::sat_sample(bbc_pkg::t_acc'(w_rb) + bbc_pkg::t_acc'(w_s1_cur));
    assign w_n1 = bbc_pkg::sat_state(bbc_pkg::t_acc'(r_rkb) - bbc_pkg::t_acc'(w_rp)
                                     + bbc_pkg::t_acc'(w_s2_cur));
    assign w_n2 = bbc_pkg::sat_state(bbc_pkg::t_acc'(r_rb) - bbc_pkg::t_acc'(w_rp));

    assign w_m1    = bbc_pkg::mag(r_n1);
    assign w_m2    = bbc_pkg::mag(r_n2);
    assign w_mmax  = (w_m1 > w_m2) ? w_m1 : w_m2;
    assign w_flush = w_mmax < bbc_pkg::t_mag'(i_cfg.thr);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_x) begin
            r_x <= i_sample;
        end else if (i_ctrl.pass_y) begin
            r_x <= r_y;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_ctrl.cap_y) begin
            r_rb  <= w_rb;
            r_rkb <= w_rkb;
            r_y   <= w_y;
        end
        if (i_ctrl.cap_n1) begin
            r_n1 <= w_n1;
        end
        if (i_ctrl.cap_n2) begin
            r_n2 <= w_n2;
        end
        if (i_ctrl.load_out) begin
            r_out <= r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1[0] <= '0;
            r_s1[1] <= '0;
            r_s2[0] <= '0;
            r_s2[1] <= '0;
        end else begin
            if (i_ctrl.commit) begin
                r_s1[i_ctrl.sec] <= w_flush ? '0 : r_n1;
                r_s2[i_ctrl.sec] <= w_flush ? '0 : r_n2;
            end
            if (i_ctrl.clr_second) begin
                r_s1[1] <= '0;
                r_s2[1] <= '0;
            end
        end
    end

    assign o_sample = r_out;

endmodule

`default_nettype wire

// File: rtl/core/bbc_sequencer.sv
`default_nettype none

module bbc_sequencer (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_mode,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output bbc_pkg::t_dp_ctrl   o_ctrl
);

    bbc_pkg::t_seq_state r_state;
    bbc_pkg::t_seq_state n_state;
    logic                r_sec;
    logic                n_sec;
    logic                r_out_valid;
    logic                w_last;
    logic                w_out_free;

    // highpass stops after the first section
    assign w_last     = i_mode || r_sec;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_sec   = r_sec;
        case (r_state)
            bbc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = bbc_pkg::S_MB;
                    n_sec   = 1'b0;
                end
            end
            bbc_pkg::S_MB: n_state = bbc_pkg::S_YC;
            bbc_pkg::S_YC: n_state = bbc_pkg::S_M1;
            bbc_pkg::S_M1: n_state = bbc_pkg::S_M2;
            bbc_pkg::S_M2: n_state = bbc_pkg::S_N2;
            bbc_pkg::S_N2: n_state = bbc_pkg::S_FL;
            bbc_pkg::S_FL: begin
                if (!w_last) begin
                    n_state = bbc_pkg::S_MB;
                    n_sec   = 1'b1;
                end else if (w_out_free) begin
                    n_state = bbc_pkg::S_IDLE;
                    n_sec   = 1'b0;
                end
            end
            default: n_state = bbc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl         = '0;
        o_ctrl.sec     = r_sec;
        o_ctrl.mul_sel = bbc_pkg::MUL_B0;
        case (r_state)
            bbc_pkg::S_IDLE: o_ctrl.load_x = i_in_valid;
            bbc_pkg::S_MB: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = bbc_pkg::MUL_B0;
            end
            bbc_pkg::S_YC: o_ctrl.cap_y = 1'b1;
            bbc_pkg::S_M1: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = bbc_pkg::MUL_A1;
            end
            bbc_pkg::S_M2: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = bbc_pkg::MUL_A2;
                o_ctrl.cap_n1  = 1'b1;
            end
            bbc_pkg::S_N2: o_ctrl.cap_n2 = 1'b1;
            bbc_pkg::S_FL: begin
                if (!w_last) begin
                    o_ctrl.commit = 1'b1;
                    o_ctrl.pass_y = 1'b1;
                end else if (w_out_free) begin
                    // hold states until the output register can take the item
                    o_ctrl.commit     = 1'b1;
                    o_ctrl.load_out   = 1'b1;
                    o_ctrl.clr_second = i_mode;
                end
            end
            default: o_ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bbc_pkg::S_IDLE;
            r_sec       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sec   <= n_sec;
            if (o_ctrl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == bbc_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/core/butterworth_biquad_cascade_core.sv
// Fourth-order IIR filter: two transposed-direct-form-2 biquad sections in
// series, sharing one 24 x SAMPLE_BITS multiplier under a small sequencer.
// Channels: i_in carries one Q1.23 sample per item, o_out one filtered
// sample per item, i_cfg writes the eight mode, coefficient and threshold
// registers by index (always ready; write only while no sample is in flight).
// Each section steps through b0*x, output sum, a1*y, a2*y, second state,
// then the flush compare and state update. The one multiplier serves the
// b0*x, a1*y and a2*y steps of both sections.
// Lowpass: an accepted item runs section one, then section two, and its
// result is loaded into the output register after section two. Highpass
// runs section one only. A new item is taken once the last one is loaded.
// i_in.ready is high only while the sequencer is idle. The result sits in an
// output register; while the receiver stalls, the next item is still
// accepted and processed, and holds in its last step until that register
// frees up.
// Reset (i_rst_n low, synchronous) clears all filter states, the
// configuration registers and the output valid.
`default_nettype none

module butterworth_biquad_cascade_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bbc_in_if.sink      i_in,
    bbc_out_if.source   o_out,
    bbc_cfg_if.sink     i_cfg
);

    bbc_pkg::t_cfg      w_cfg;
    bbc_pkg::t_dp_ctrl  w_ctrl;
    logic               w_in_ready;
    logic               w_out_valid;
    bbc_pkg::t_sample   w_out_sample;

    assign i_cfg.ready = 1'b1;

    bbc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (w_cfg)
    );

    bbc_sequencer u_sequencer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (w_cfg.mode),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_ctrl      (w_ctrl)
    );

    bbc_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_ctrl   (w_ctrl),
        .i_sample (i_in.sample_in),
        .o_sample (w_out_sample)
    );

    assign i_in.ready       = w_in_ready;
    assign o_out.valid      = w_out_valid;
    assign o_out.sample_out = w_out_sample;

endmodule

`default_nettype wire

// File: rtl/core/bbc_checker.sv
`default_nettype none

module bbc_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire bbc_pkg::t_sample    i_out_sample,
    input wire logic                i_cfg_ready
);

    // one item at a time: an accept closes the input until the work is done
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted again right after an accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_sample)))
        else $error("stalled result changed or dropped");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("block not idle after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("register port not ready");

endmodule

bind butterworth_biquad_cascade_core bbc_checker u_bbc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample_out),
    .i_cfg_ready  (i_cfg.ready)
);

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import bbc_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 40;
    localparam int LIMIT_NS      = 5_000_000;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 100;
    localparam int MODE_FILL_BITS = CFG_DATA_BITS - 1;
    localparam int THR_FILL_BITS  = CFG_DATA_BITS - THR_BITS;
    localparam longint COEF_ONE  = longint'(1) <<< COEF_FRAC;

    localparam t_sample SMP_HI  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample SMP_LO  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam t_coef   COEF_HI = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam t_coef   COEF_LO = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam t_cfg_index UNUSED_IDX = t_cfg_index'(REG_THR) + 1'b1;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_WRITE,
        OP_DRAIN
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        t_cfg_index index;
        t_cfg_data  data;
        t_sample    sample;
    } t_bench_op;

    logic i_clk;
    logic i_rst_n;

    bbc_in_if  in_if ();
    bbc_out_if out_if ();
    bbc_cfg_if cfg_if ();

    butterworth_biquad_cascade_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // filter copy: registers and section states
    logic    mode_r;
    t_coef   b0_r [2];
    t_coef   a1_r [2];
    t_coef   a2_r [2];
    t_thr    thr_r;
    longint  sec_s1 [2];
    longint  sec_s2 [2];

    t_bench_op pending_q [$];
    t_sample   filtered_q [$];

    int  mismatches;
    int  outstanding;
    int  quiet_cycles;
    int  gap_left;
    int  stall_left;
    bit  calm_in;
    bit  calm_out;
    bit  in_fire;
    bit  cfg_fire;
    bit  out_fire;
    bit  in_next;
    bit  cfg_next;
    t_bench_op op;
    t_sample   want;

    function automatic longint to_state_grid(longint p);
        return (p + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    endfunction

    function automatic longint clamp(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // one TDF-II section; k is the b1/b0 ratio (+2 lowpass, -2 highpass)
    function automatic longint run_section(int s, longint x, longint k);
        longint pb;
        longint y;
        longint n1;
        longint n2;
        longint m1;
        longint m2;
        pb = longint'(b0_r[s]) * x;
        y  = clamp(to_state_grid(pb) + sec_s1[s], SAMPLE_BITS);
        n1 = clamp(to_state_grid(k * pb) - to_state_grid(longint'(a1_r[s]) * y) + sec_s2[s],
                   STATE_BITS);
        n2 = clamp(to_state_grid(pb) - to_state_grid(longint'(a2_r[s]) * y), STATE_BITS);
        m1 = (n1 < 0) ? -n1 : n1;
        m2 = (n2 < 0) ? -n2 : n2;
        if (((m1 > m2) ? m1 : m2) < longint'(thr_r)) begin
            n1 = 0;
            n2 = 0;
        end
        sec_s1[s] = n1;
        sec_s2[s] = n2;
        return y;
    endfunction

    function automatic t_sample filter_sample(t_sample x_in);
        longint y;
        if (mode_r) begin
            y = run_section(0, longint'(x_in), -2);
            sec_s1[1] = 0;
            sec_s2[1] = 0;
        end else begin
            y = run_section(0, longint'(x_in), 2);
            y = run_section(1, y, 2);
        end
        return t_sample'(y);
    endfunction

    function automatic void load_register(t_cfg_index idx, t_cfg_data d);
        case (idx)
            REG_MODE: mode_r  = d[0];
            REG_FB0:  b0_r[0] = t_coef'(d);
            REG_FA1:  a1_r[0] = t_coef'(d);
            REG_FA2:  a2_r[0] = t_coef'(d);
            REG_SB0:  b0_r[1] = t_coef'(d);
            REG_SA1:  a1_r[1] = t_coef'(d);
            REG_SA2:  a2_r[1] = t_coef'(d);
            REG_THR:  thr_r   = d[THR_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(99);
        if (calm || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    // pole pair inside the stability triangle, |a2| <= 0.9
    function automatic logic [2*COEF_BITS-1:0] stable_poles();
        int a1;
        int a2;
        int lim;
        a2  = int'($urandom_range(2 * 3774873)) - 3774873;
        lim = (int'(COEF_ONE) + a2) / 100 * 95;
        a1  = int'($urandom_range(2 * lim)) - lim;
        return {t_coef'(a1), t_coef'(a2)};
    endfunction

    task automatic queue_sample(t_sample s);
        pending_q.push_back('{OP_SAMPLE, '0, '0, s});
    endtask

    task automatic queue_write(t_cfg_index idx, t_cfg_data d);
        pending_q.push_back('{OP_WRITE, idx, d, '0});
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        in_if.valid      = 1'b0;
        in_if.sample_in  = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        out_if.ready     = 1'b0;
        mode_r = 1'b0;
        thr_r  = '0;
        for (int s = 0; s < 2; s++) begin
            b0_r[s] = '0;
            a1_r[s] = '0;
            a2_r[s] = '0;
            sec_s1[s] = 0;
            sec_s2[s] = 0;
        end
        mismatches = 0;
        outstanding = 0;
        quiet_cycles = 0;
        gap_left = 0;
        stall_left = 0;
        calm_in = 1'b0;
        calm_out = 1'b0;
    end

    initial begin : stimulus
        t_sample   s;
        t_sample   last_s;
        logic [2*COEF_BITS-1:0] poles;
        int        r;
        t_thr      thr;
        i_rst_n = 1'b0;

        // all registers still zero
        queue_sample(SMP_HI);
        queue_sample(SMP_LO);

        // lowpass at full-scale coefficients: saturate states and outputs
        queue_write(REG_MODE, '0);
        queue_write(REG_FB0, COEF_HI);
        queue_write(REG_FA1, COEF_LO);
        queue_write(REG_FA2, COEF_HI);
        queue_write(REG_SB0, COEF_LO);
        queue_write(REG_SA1, COEF_HI);
        queue_write(REG_SA2, COEF_LO);
        queue_write(REG_THR, '0);
        queue_sample(SMP_HI);
        queue_sample(SMP_HI);
        queue_sample(SMP_LO);
        queue_sample(SMP_LO);
        queue_sample('0);
        queue_sample(t_sample'(1));

        // highpass with upper data bits set; full threshold flushes small states
        queue_write(REG_MODE, '1);
        queue_write(REG_FB0, t_coef'(1 << 21));
        queue_write(REG_FA1, t_coef'(-(1 << 22) + 12345));
        queue_write(REG_FA2, t_coef'(1 << 20));
        queue_write(REG_THR, '1);
        queue_sample(t_sample'(1));
        queue_sample(t_sample'(-1));
        queue_sample('0);
        queue_sample(t_sample'(12345));
        queue_sample(SMP_LO);
        queue_sample(SMP_HI);

        // back to lowpass: section one keeps its state, unused indexes do nothing
        queue_write(UNUSED_IDX, '1);
        queue_write(t_cfg_index'('1), '0);
        queue_write(REG_MODE, '0);
        queue_write(REG_THR, '0);
        queue_write(REG_SB0, t_coef'(1 << 21));
        queue_write(REG_SA1, t_coef'(-(1 << 21)));
        queue_write(REG_SA2, t_coef'(1 << 20));
        queue_sample(SMP_HI);
        queue_sample(t_sample'(-5));
        queue_sample(t_sample'(100));
        queue_sample(SMP_LO);
        queue_sample('0);

        last_s = '0;
        for (int ph = 0; ph < PHASES; ph++) begin
            queue_write(REG_MODE, {MODE_FILL_BITS'($urandom), (ph % 3 == 1)});
            for (int sec = 0; sec < 2; sec++) begin
                if ($urandom_range(9) < 3) begin
                    queue_write(sec ? REG_SB0 : REG_FB0, t_cfg_data'($urandom));
                    queue_write(sec ? REG_SA1 : REG_FA1, t_cfg_data'($urandom));
                    queue_write(sec ? REG_SA2 : REG_FA2, t_cfg_data'($urandom));
                end else begin
                    poles = stable_poles();
                    queue_write(sec ? REG_SB0 : REG_FB0,
                                t_cfg_data'(int'($urandom_range(1 << 21)) - (1 << 20)));
                    queue_write(sec ? REG_SA1 : REG_FA1, poles[2*COEF_BITS-1:COEF_BITS]);
                    queue_write(sec ? REG_SA2 : REG_FA2, poles[COEF_BITS-1:0]);
                end
            end
            r = $urandom_range(3);
            case (r)
                0: thr = '0;
                1: thr = t_thr'($urandom_range(64, 1));
                2: thr = '1;
                default: thr = t_thr'($urandom);
            endcase
            queue_write(REG_THR, {THR_FILL_BITS'($urandom), thr});
            if ($urandom_range(2) == 0) begin
                queue_write(t_cfg_index'($urandom_range(2**CFG_IDX_BITS - 1, UNUSED_IDX)),
                            t_cfg_data'($urandom));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && ph % 2 == 0) begin
                    // let the block run dry before going on
                    pending_q.push_back('{OP_DRAIN, '0, '0, '0});
                end
                r = $urandom_range(99);
                if (r < 45) begin
                    s = t_sample'($urandom);
                end else if (r < 75) begin
                    s = t_sample'(int'($urandom_range(2048)) - 1024);
                end else if (r < 85) begin
                    s = '0;
                end else if (r < 92) begin
                    s = $urandom_range(1) ? SMP_HI : SMP_LO;
                end else begin
                    s = last_s;
                end
                last_s = s;
                queue_sample(s);
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (pending_q.size() != 0 || in_if.valid || cfg_if.valid || outstanding != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (filtered_q.size() != 0) begin
            $display("%0t missing %0d results", $time, filtered_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("%0t timeout", $time);
        $display("status: fail");
        $finish;
    end

    // driver: samples on in_if, register writes on cfg_if while the block is idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid  <= 1'b0;
            cfg_if.valid <= 1'b0;
            outstanding  = 0;
            quiet_cycles = 0;
            gap_left     = 0;
        end else begin
            in_fire  = in_if.valid && in_if.ready;
            cfg_fire = cfg_if.valid && cfg_if.ready;
            out_fire = out_if.valid && out_if.ready;
            if (in_fire) begin
                filtered_q.push_back(filter_sample(in_if.sample_in));
                gap_left = pick_gap(calm_in);
            end
            if (cfg_fire) begin
                load_register(cfg_if.index, cfg_if.data);
            end
            outstanding  = outstanding + int'(in_fire) - int'(out_fire);
            quiet_cycles = (outstanding == 0) ? quiet_cycles + 1 : 0;
            if ($urandom_range(249) == 0) begin
                calm_in = !calm_in;
            end
            in_next  = in_if.valid && !in_fire;
            cfg_next = cfg_if.valid && !cfg_fire;
            if (!in_next && !cfg_next) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() != 0) begin
                    op = pending_q[0];
                    if (op.kind == OP_SAMPLE) begin
                        in_next = 1'b1;
                        in_if.sample_in <= op.sample;
                        void'(pending_q.pop_front());
                    end else if (quiet_cycles >= SETTLE_CYCLES) begin
                        if (op.kind == OP_WRITE) begin
                            cfg_next = 1'b1;
                            cfg_if.index <= op.index;
                            cfg_if.data  <= op.data;
                        end
                        void'(pending_q.pop_front());
                    end
                end
            end
            in_if.valid  <= in_next;
            cfg_if.valid <= cfg_next;
        end
    end

    // monitor: check each filtered item, stall the output at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (filtered_q.size() == 0) begin
                    $display("%0t unexpected sample_out %0d", $time, out_if.sample_out);
                    mismatches++;
                end else begin
                    want = filtered_q.pop_front();
                    if (out_if.sample_out !== want) begin
                        $display("%0t sample_out expected %0d got %0d",
                                 $time, want, out_if.sample_out);
                        mismatches++;
                    end
                end
            end
            if ($urandom_range(249) == 0) begin
                calm_out = !calm_out;
            end
            out_if.ready <= (stall_left == 0);
            if (stall_left > 0) begin
                stall_left--;
            end else if ($urandom_range(3) == 0) begin
                stall_left = pick_gap(calm_out);
            end
        end
    end

endmodule
